// ----- rtl/dls_pkg.sv -----
// shared types and constants for the debounced lap stopwatch
`default_nettype none

package dls_pkg;

	localparam int IN_W  = 40;
	localparam int OUT_W = 88;

	localparam logic [7:0]  TRIGGER_RESET = 8'd5;
	localparam logic [15:0] LAP_MAX       = 16'hFFFF;

	typedef struct packed {
		logic count_pulse;
		logic pause_pulse;
	} pulse_t;

	typedef struct packed {
		logic [31:0] state_time_ms;
		logic        running;
		logic [31:0] run_time_ms;
		logic [15:0] laps;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/debounced_lap_stopwatch.sv -----
// top level of the debounced lap stopwatch
`default_nettype none

// Takes one button/timestamp sample per clock unless the output stalls, and returns
// one result per sample. A sample passes an input register, and its result is shown
// on the master side once the result register captures it, which waits while an
// earlier result stalls. With the output taken every cycle the block sustains one
// sample per cycle, set by the single update of the debounce and stopwatch state
// between those two registers. The trigger count resets to 5; the user must write
// it through cfg_wen/cfg_wdata only while no sample is in flight; nothing enforces it.

module debounced_lap_stopwatch (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wen,
	input  wire logic [7:0]               cfg_wdata,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// count_button, pause_button, time_ms[31:0], zero pad
	input  wire logic [dls_pkg::IN_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// laps[15:0], run_time_ms[31:0], running, state_time_ms[31:0], zero pad
	output logic [dls_pkg::OUT_W-1:0]     m_tdata
);

	import dls_pkg::*;

	logic [7:0]  trigger_q;
	logic        valid_s1;
	logic        count_s1;
	logic        pause_s1;
	logic [31:0] time_s1;
	logic        valid_s2;
	result_t     result_s2;
	logic        advance;
	logic        count_pulse;
	logic        pause_pulse;
	pulse_t      pulses;
	result_t     result;

	assign advance  = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_q <= TRIGGER_RESET;
		end else if (cfg_wen) begin
			trigger_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			count_s1 <= s_tdata[0];
			pause_s1 <= s_tdata[1];
			time_s1  <= s_tdata[33:2];
		end
	end

	dls_debounce u_count_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.raw     (count_s1),
		.trigger (trigger_q),
		.pulse   (count_pulse)
	);

	dls_debounce u_pause_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.raw     (pause_s1),
		.trigger (trigger_q),
		.pulse   (pause_pulse)
	);

	assign pulses = {count_pulse, pause_pulse};

	dls_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.time_ms (time_s1),
		.pulses  (pulses),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, result_s2};

endmodule

`default_nettype wire

// ----- rtl/dls_debounce.sv -----
// integrator debounce filter with rising-edge pulse
`default_nettype none

module dls_debounce (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       raw,
	input  wire logic [7:0] trigger,
	output logic            pulse
);

	logic [7:0] level_q;
	logic       pressed_q;
	logic [7:0] level_nx;
	logic       pressed_nx;

	always_comb begin
		level_nx = level_q;
		if (raw) begin
			if (level_q < trigger) begin
				level_nx = level_q + 8'd1;
			end
		end else begin
			if (level_q != 8'd0) begin
				level_nx = level_q - 8'd1;
			end
		end
		pressed_nx = pressed_q;
		if (level_nx == 8'd0) begin
			pressed_nx = 1'b0;
		end else if (level_nx == trigger) begin
			pressed_nx = 1'b1;
		end
	end

	assign pulse = pressed_nx & ~pressed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= 8'd0;
			pressed_q <= 1'b0;
		end else if (en) begin
			level_q   <= level_nx;
			pressed_q <= pressed_nx;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dls_core.sv -----
// run/pause machine, lap counter and time accumulators
`default_nettype none

module dls_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic [31:0]    time_ms,
	input  wire dls_pkg::pulse_t pulses,
	output dls_pkg::result_t    result
);

	import dls_pkg::*;

	logic        running_q;
	logic [15:0] laps_q;
	logic [31:0] run_total_q;
	logic [31:0] state_start_q;
	logic [31:0] prev_time_q;

	logic        running_nx;
	logic [15:0] laps_nx;
	logic [31:0] run_total_nx;
	logic [31:0] state_start_nx;

	always_comb begin
		running_nx   = running_q;
		laps_nx      = laps_q;
		run_total_nx = run_total_q;
		if (running_q) begin
			run_total_nx = run_total_q + (time_ms - prev_time_q);
			if (pulses.count_pulse && laps_q != LAP_MAX) begin
				laps_nx = laps_q + 16'd1;
			end
			if (pulses.pause_pulse) begin
				running_nx = 1'b0;
			end
		end else begin
			if (pulses.count_pulse || pulses.pause_pulse) begin
				running_nx = 1'b1;
			end
		end
		state_start_nx = (running_nx != running_q) ? time_ms : state_start_q;
	end

	assign result.laps          = laps_nx;
	assign result.run_time_ms   = run_total_nx;
	assign result.running       = running_nx;
	assign result.state_time_ms = time_ms - state_start_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			laps_q        <= 16'd0;
			run_total_q   <= 32'd0;
			state_start_q <= 32'd0;
			prev_time_q   <= 32'd0;
		end else if (en) begin
			running_q     <= running_nx;
			laps_q        <= laps_nx;
			run_total_q   <= run_total_nx;
			state_start_q <= state_start_nx;
			prev_time_q   <= time_ms;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dls_checker.sv -----
// port-level checks for the debounced lap stopwatch, bound to the top level
`default_nettype none

module dls_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [dls_pkg::OUT_W-1:0] m_tdata
);

	import dls_pkg::*;

	result_t res;
	logic    out_acc;
	logic    prev_valid_q;
	result_t prev_q;

	assign res     = m_tdata[$bits(result_t)-1:0];
	assign out_acc = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
		end else if (out_acc) begin
			prev_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_q <= res;
		end
	end

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// a state change restarts the state timer
	assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && prev_valid_q && (res.running != prev_q.running)
		|-> res.state_time_ms == 32'd0)
		else $error("state timer not restarted on state change");

	// no run time added for a sample taken while paused
	assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && prev_valid_q && !prev_q.running
		|-> res.run_time_ms == prev_q.run_time_ms)
		else $error("run time grew while paused");

	// laps only change while running and never go down
	assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && prev_valid_q
		|-> (res.laps >= prev_q.laps)
			&& (prev_q.running || res.laps == prev_q.laps))
		else $error("lap count moved wrongly");

endmodule

bind debounced_lap_stopwatch dls_checker u_dls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
